// ===== sv/spct_pkg.sv =====
package spct_pkg;

    localparam int unsigned COORD_W    = 16;
    localparam int unsigned RATIO_W    = 32;
    localparam int unsigned RATIO_FRAC = 16;
    localparam int unsigned RATIO_INT  = RATIO_W - 1 - RATIO_FRAC;
    localparam int unsigned DIV_STAGES = RATIO_W - 1;
    localparam int unsigned NUM_W      = 38;
    localparam int unsigned DEN_W      = 37;
    localparam int unsigned LANES      = 4;
    // sideband delay from the circle lane result to the divider output
    localparam int unsigned DLY_LEN    = DIV_STAGES - 2;
    // accept edge to the edge that ends the strobe cycle
    localparam int unsigned SAMPLE_LAT = 5 + DIV_STAGES;

    localparam logic [2:0] REQ_RECT_RECT = 3'd0;
    localparam logic [2:0] REQ_CIRC_CIRC = 3'd1;
    localparam logic [2:0] REQ_SEG_SEG   = 3'd2;
    localparam logic [2:0] REQ_RECT_CIRC = 3'd3;
    localparam logic [2:0] REQ_RECT_SEG  = 3'd4;
    localparam logic [2:0] REQ_CIRC_SEG  = 3'd5;

    typedef struct packed {
        logic [2:0]                 req_type;
        logic signed [COORD_W-1:0]  a_x;
        logic signed [COORD_W-1:0]  a_y;
        logic signed [COORD_W-1:0]  a_p;
        logic signed [COORD_W-1:0]  a_q;
        logic signed [COORD_W-1:0]  b_x;
        logic signed [COORD_W-1:0]  b_y;
        logic signed [COORD_W-1:0]  b_p;
        logic signed [COORD_W-1:0]  b_q;
    } spct_req_t;

    typedef struct packed {
        logic                       hit;
        logic                       ratio_valid;
        logic signed [RATIO_W-1:0]  ratio_a;
        logic signed [RATIO_W-1:0]  ratio_b;
    } spct_res_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic ratio_valid;
    } spct_side_t;

endpackage

// ===== sv/spct_ratio_div.sv =====
module spct_ratio_div (
    input  logic                                   clk,
    input  logic signed [spct_pkg::NUM_W-1:0]      num,
    input  logic signed [spct_pkg::DEN_W-1:0]      den,
    output logic signed [spct_pkg::RATIO_W-1:0]    ratio
);

    localparam int unsigned AN_W  = spct_pkg::NUM_W - 1;
    localparam int unsigned AD_W  = spct_pkg::DEN_W - 1;
    localparam int unsigned REM_W = AD_W;
    localparam int unsigned Q_W   = spct_pkg::RATIO_W - 1;
    localparam int unsigned NS    = spct_pkg::DIV_STAGES;
    localparam int unsigned EXT_W = AN_W + spct_pkg::RATIO_FRAC;
    localparam int unsigned SAT_W = AD_W + spct_pkg::RATIO_INT;

    logic [AN_W-1:0]  an_reg  [0:NS];
    logic [AD_W-1:0]  ad_reg  [0:NS];
    logic [REM_W-1:0] rem_reg [0:NS];
    logic [Q_W-1:0]   q_reg   [0:NS];
    logic             neg_reg [0:NS];
    logic             sat_reg [0:NS];

    logic [REM_W-1:0] rem_next [1:NS];
    logic [Q_W-1:0]   q_next   [1:NS];
    logic [REM_W:0]   rem_s    [0:NS-1];
    logic [EXT_W-1:0] an_ext   [0:NS-1];
    logic             ge       [0:NS-1];

    logic signed [spct_pkg::NUM_W-1:0] num_abs;
    logic signed [spct_pkg::DEN_W-1:0] den_abs;
    logic [AN_W-1:0]  an_next;
    logic [AD_W-1:0]  ad_next;
    logic             sat_next;
    logic             neg_next;
    logic [REM_W-1:0] rem0_next;
    logic [spct_pkg::RATIO_W-1:0] mag;

    always_comb
    begin
        num_abs   = (num < 0) ? -num : num;
        den_abs   = (den < 0) ? -den : den;
        an_next   = num_abs[AN_W-1:0];
        ad_next   = den_abs[AD_W-1:0];
        neg_next  = (num < 0) != (den < 0);
        // integer part would not fit the result
        sat_next  = SAT_W'(an_next) >= {ad_next, spct_pkg::RATIO_INT'(0)};
        rem0_next = REM_W'(an_next >> spct_pkg::RATIO_INT);
    end

    // one quotient bit per stage, msb first
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            an_ext[k] = {an_reg[k], spct_pkg::RATIO_FRAC'(0)};
            rem_s[k]  = {rem_reg[k], an_ext[k][NS-1-k]};
            ge[k]     = rem_s[k] >= {1'b0, ad_reg[k]};
            rem_next[k+1] = ge[k] ? REM_W'(rem_s[k] - {1'b0, ad_reg[k]})
                                  : rem_s[k][REM_W-1:0];
            q_next[k+1] = q_reg[k];
            q_next[k+1][NS-1-k] = ge[k];
        end
    end

    always_ff @(posedge clk)
    begin
        an_reg[0]  <= an_next;
        ad_reg[0]  <= ad_next;
        rem_reg[0] <= rem0_next;
        q_reg[0]   <= '0;
        neg_reg[0] <= neg_next;
        sat_reg[0] <= sat_next;
        for (int k = 0; k < NS; k++)
        begin
            an_reg[k+1]  <= an_reg[k];
            ad_reg[k+1]  <= ad_reg[k];
            rem_reg[k+1] <= rem_next[k+1];
            q_reg[k+1]   <= q_next[k+1];
            neg_reg[k+1] <= neg_reg[k];
            sat_reg[k+1] <= sat_reg[k];
        end
    end

    always_comb
    begin
        mag = {1'b0, q_reg[NS]};
        if (sat_reg[NS])
            ratio = neg_reg[NS] ? {1'b1, Q_W'(0)} : {1'b0, {Q_W{1'b1}}};
        else
            ratio = neg_reg[NS] ? $signed(-mag) : $signed(mag);
    end

endmodule

// ===== sv/shape_pair_collision_test.sv =====
// Channel   Ports                  Moves
// request   start, busy, req       one shape pair, taken when start && !busy
// result    done, result           hit flag and segment ratios, one cycle wide
//
// One request per cycle while busy is low.
// The depth is set by the ratio divider, one quotient bit per stage.
// busy is high only from reset until the first clock after it.
// Reset clears every valid bit in flight and drops those results; outside reset no accepted result is lost.
// The receiver cannot stall: done is a pulse and must be taken.
module shape_pair_collision_test (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  spct_pkg::spct_req_t    req,
    output logic                   done,
    output spct_pkg::spct_res_t    result
);

    localparam int unsigned L  = spct_pkg::LANES;
    localparam int unsigned DL = spct_pkg::DLY_LEN;

    logic busy_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    spct_pkg::spct_req_t req1_reg;
    spct_pkg::spct_side_t dl_reg [0:DL-1];
    logic done_reg;
    spct_pkg::spct_res_t res_reg;

    // stage 2 operands
    logic signed [16:0] ax2, ay2, ap2, aq2, bx2, by2, bp2, bq2;
    logic signed [17:0] ap18, aq18, bp18, bq18, w2, h2, xl, xr, yt, yb;
    logic signed [17:0] e_x [0:L-1];
    logic signed [17:0] e_y [0:L-1];
    logic signed [17:0] e_vx [0:L-1];
    logic signed [17:0] e_vy [0:L-1];
    logic signed [16:0] cx [0:L-1];
    logic signed [16:0] cy [0:L-1];
    logic signed [16:0] cr [0:L-1];
    logic signed [17:0] csx [0:L-1];
    logic signed [17:0] csy [0:L-1];
    logic signed [17:0] s1x [0:L-1];
    logic signed [17:0] s1y [0:L-1];
    logic signed [18:0] cex [0:L-1];
    logic signed [18:0] cey [0:L-1];

    logic signed [18:0] c_d0x_next [0:L-1], c_d0y_next [0:L-1];
    logic signed [19:0] c_d1x_next [0:L-1], c_d1y_next [0:L-1];
    logic signed [17:0] c_vx_next [0:L-1], c_vy_next [0:L-1];
    logic signed [16:0] c_r_next [0:L-1];
    logic               c_en_next [0:L-1];
    logic signed [18:0] s_dx_next [0:L-1], s_dy_next [0:L-1];
    logic signed [17:0] s_v1x_next [0:L-1], s_v1y_next [0:L-1];
    logic signed [17:0] s_v2x_next [0:L-1], s_v2y_next [0:L-1];
    logic               s_en_next [0:L-1];
    logic signed [17:0] cc_dx_next, cc_dy_next, cc_rs_next;
    logic               cc_en_next, rr_hit_next, ss_next;

    logic signed [18:0] c_d0x_reg [0:L-1], c_d0y_reg [0:L-1];
    logic signed [19:0] c_d1x_reg [0:L-1], c_d1y_reg [0:L-1];
    logic signed [17:0] c_vx_reg [0:L-1], c_vy_reg [0:L-1];
    logic signed [16:0] c_r_reg [0:L-1];
    logic               c_en2_reg [0:L-1];
    logic signed [18:0] s_dx_reg [0:L-1], s_dy_reg [0:L-1];
    logic signed [17:0] s_v1x_reg [0:L-1], s_v1y_reg [0:L-1];
    logic signed [17:0] s_v2x_reg [0:L-1], s_v2y_reg [0:L-1];
    logic               s_en2_reg [0:L-1];
    logic signed [17:0] cc_dx_reg, cc_dy_reg, cc_rs_reg;
    logic               cc_en2_reg, rr_hit2_reg, ss2_reg;

    // stage 3: products and their sums
    logic signed [38:0] c_pt0_reg [0:L-1];
    logic signed [40:0] c_pt1_reg [0:L-1];
    logic signed [33:0] c_rr_reg [0:L-1];
    logic signed [36:0] c_vv_reg [0:L-1];
    logic signed [37:0] c_cross_reg [0:L-1];
    logic signed [37:0] c_dot0_reg [0:L-1];
    logic signed [38:0] c_dot1_reg [0:L-1];
    logic               c_en3_reg [0:L-1];
    logic signed [36:0] s_den_reg [0:L-1];
    logic signed [37:0] s_n1_reg [0:L-1], s_n2_reg [0:L-1];
    logic               s_en3_reg [0:L-1];
    logic signed [36:0] cc_d_reg, cc_r_reg;
    logic               cc_en3_reg, rr_hit3_reg, ss3_reg;

    // stage 4
    logic               c_pt4_reg [0:L-1], c_lin4_reg [0:L-1];
    logic [34:0]        c_ac_reg [0:L-1];
    logic [32:0]        c_r2_reg [0:L-1];
    logic [33:0]        c_vv4_reg [0:L-1];
    logic               hit4_reg, rv4_reg;
    logic signed [37:0] c_acs [0:L-1];
    logic               s_hit [0:L-1];
    logic               s_any;

    // stage 5
    logic [35:0]        c_ah2_reg [0:L-1];
    logic [34:0]        c_ahal_reg [0:L-1];
    logic [33:0]        c_al2_reg [0:L-1];
    logic [49:0]        c_rvh_reg [0:L-1], c_rvl_reg [0:L-1];
    logic               c_pt5_reg [0:L-1], c_lin5_reg [0:L-1];
    logic               hit5_reg, rv5_reg;

    // stage 6
    logic [69:0]        ac2 [0:L-1];
    logic [69:0]        rvv [0:L-1];
    logic               c_any;
    logic               hit6_reg, rv6_reg;

    logic signed [spct_pkg::RATIO_W-1:0] div_a, div_b;

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int j = 0; j < DL; j++)
                dl_reg[j] <= '0;
        end
        else
        begin
            busy_reg  <= 1'b0;
            v1_reg    <= start && !busy_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            dl_reg[0] <= '{valid: v6_reg, hit: hit6_reg, ratio_valid: rv6_reg};
            for (int j = 1; j < DL; j++)
                dl_reg[j] <= dl_reg[j-1];
            done_reg  <= dl_reg[DL-1].valid;
        end
    end

    // stage 2: edges, lane operands and differences
    always_comb
    begin
        ax2  = $signed({req1_reg.a_x, 1'b0});
        ay2  = $signed({req1_reg.a_y, 1'b0});
        ap2  = $signed({req1_reg.a_p, 1'b0});
        aq2  = $signed({req1_reg.a_q, 1'b0});
        bx2  = $signed({req1_reg.b_x, 1'b0});
        by2  = $signed({req1_reg.b_y, 1'b0});
        bp2  = $signed({req1_reg.b_p, 1'b0});
        bq2  = $signed({req1_reg.b_q, 1'b0});
        ap18 = 18'(req1_reg.a_p);
        aq18 = 18'(req1_reg.a_q);
        bp18 = 18'(req1_reg.b_p);
        bq18 = 18'(req1_reg.b_q);
        w2   = 18'(ap2);
        h2   = 18'(aq2);
        xl   = 18'(ax2) - ap18;
        xr   = 18'(ax2) + ap18;
        yt   = 18'(ay2) - aq18;
        yb   = 18'(ay2) + aq18;

        // left going up, top going right, right going down, bottom going left
        e_x[0] = xl; e_y[0] = yb; e_vx[0] = '0;  e_vy[0] = -h2;
        e_x[1] = xl; e_y[1] = yt; e_vx[1] = w2;  e_vy[1] = '0;
        e_x[2] = xr; e_y[2] = yt; e_vx[2] = '0;  e_vy[2] = h2;
        e_x[3] = xr; e_y[3] = yb; e_vx[3] = -w2; e_vy[3] = '0;

        for (int k = 0; k < L; k++)
        begin
            cx[k]            = bx2;
            cy[k]            = by2;
            cr[k]            = bp2;
            csx[k]           = e_x[k];
            csy[k]           = e_y[k];
            c_vx_next[k]     = e_vx[k];
            c_vy_next[k]     = e_vy[k];
            c_en_next[k]     = req1_reg.req_type == spct_pkg::REQ_RECT_CIRC;
            s1x[k]           = e_x[k];
            s1y[k]           = e_y[k];
            s_v1x_next[k]    = e_vx[k];
            s_v1y_next[k]    = e_vy[k];
            s_en_next[k]     = req1_reg.req_type == spct_pkg::REQ_RECT_SEG;
            if (k == 0 && req1_reg.req_type == spct_pkg::REQ_CIRC_SEG)
            begin
                cx[k]        = ax2;
                cy[k]        = ay2;
                cr[k]        = ap2;
                csx[k]       = 18'(bx2);
                csy[k]       = 18'(by2);
                c_vx_next[k] = 18'(bp2);
                c_vy_next[k] = 18'(bq2);
                c_en_next[k] = 1'b1;
            end
            if (k == 0 && req1_reg.req_type == spct_pkg::REQ_SEG_SEG)
            begin
                s1x[k]        = 18'(ax2);
                s1y[k]        = 18'(ay2);
                s_v1x_next[k] = w2;
                s_v1y_next[k] = h2;
                s_en_next[k]  = 1'b1;
            end
            c_r_next[k]   = cr[k];
            c_d0x_next[k] = 19'(cx[k]) - 19'(csx[k]);
            c_d0y_next[k] = 19'(cy[k]) - 19'(csy[k]);
            cex[k]        = 19'(csx[k]) + 19'(c_vx_next[k]);
            cey[k]        = 19'(csy[k]) + 19'(c_vy_next[k]);
            c_d1x_next[k] = 20'(cx[k]) - 20'(cex[k]);
            c_d1y_next[k] = 20'(cy[k]) - 20'(cey[k]);
            s_v2x_next[k] = 18'(bp2);
            s_v2y_next[k] = 18'(bq2);
            s_dx_next[k]  = 19'(bx2) - 19'(s1x[k]);
            s_dy_next[k]  = 19'(by2) - 19'(s1y[k]);
        end

        cc_dx_next  = 18'(bx2) - 18'(ax2);
        cc_dy_next  = 18'(by2) - 18'(ay2);
        cc_rs_next  = 18'(ap2) + 18'(bp2);
        cc_en_next  = req1_reg.req_type == spct_pkg::REQ_CIRC_CIRC;
        ss_next     = req1_reg.req_type == spct_pkg::REQ_SEG_SEG;
        rr_hit_next = (req1_reg.req_type == spct_pkg::REQ_RECT_RECT) &&
                      (18'(ax2) - ap18 <= 18'(bx2) + bp18) &&
                      (18'(ax2) + ap18 >= 18'(bx2) - bp18) &&
                      (18'(ay2) - aq18 <= 18'(by2) + bq18) &&
                      (18'(ay2) + aq18 >= 18'(by2) - bq18);
    end

    // stage 4/6 combining
    always_comb
    begin
        s_any = 1'b0;
        for (int k = 0; k < L; k++)
        begin
            c_acs[k] = (c_cross_reg[k] < 0) ? -c_cross_reg[k] : c_cross_reg[k];
            if (s_den_reg[k] > 0)
                s_hit[k] = s_n1_reg[k] >= 0 && s_n1_reg[k] <= s_den_reg[k] &&
                           s_n2_reg[k] >= 0 && s_n2_reg[k] <= s_den_reg[k];
            else
                s_hit[k] = s_den_reg[k] != 0 &&
                           s_n1_reg[k] <= 0 && s_n1_reg[k] >= s_den_reg[k] &&
                           s_n2_reg[k] <= 0 && s_n2_reg[k] >= s_den_reg[k];
            s_any = s_any | (s_en3_reg[k] & s_hit[k]);
        end
        c_any = 1'b0;
        for (int k = 0; k < L; k++)
        begin
            ac2[k] = {c_ah2_reg[k], 34'b0} + 70'({c_ahal_reg[k], 18'b0}) +
                     70'(c_al2_reg[k]);
            rvv[k] = 70'({c_rvh_reg[k], 17'b0}) + 70'(c_rvl_reg[k]);
            c_any  = c_any | c_pt5_reg[k] | (c_lin5_reg[k] && ac2[k] <= rvv[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        req1_reg <= req;
        for (int k = 0; k < L; k++)
        begin
            // stage 2
            c_d0x_reg[k]  <= c_d0x_next[k];
            c_d0y_reg[k]  <= c_d0y_next[k];
            c_d1x_reg[k]  <= c_d1x_next[k];
            c_d1y_reg[k]  <= c_d1y_next[k];
            c_vx_reg[k]   <= c_vx_next[k];
            c_vy_reg[k]   <= c_vy_next[k];
            c_r_reg[k]    <= c_r_next[k];
            c_en2_reg[k]  <= c_en_next[k];
            s_dx_reg[k]   <= s_dx_next[k];
            s_dy_reg[k]   <= s_dy_next[k];
            s_v1x_reg[k]  <= s_v1x_next[k];
            s_v1y_reg[k]  <= s_v1y_next[k];
            s_v2x_reg[k]  <= s_v2x_next[k];
            s_v2y_reg[k]  <= s_v2y_next[k];
            s_en2_reg[k]  <= s_en_next[k];
            // stage 3
            c_pt0_reg[k]   <= c_d0x_reg[k] * c_d0x_reg[k] + c_d0y_reg[k] * c_d0y_reg[k];
            c_pt1_reg[k]   <= c_d1x_reg[k] * c_d1x_reg[k] + c_d1y_reg[k] * c_d1y_reg[k];
            c_rr_reg[k]    <= c_r_reg[k] * c_r_reg[k];
            c_vv_reg[k]    <= c_vx_reg[k] * c_vx_reg[k] + c_vy_reg[k] * c_vy_reg[k];
            c_cross_reg[k] <= c_vx_reg[k] * c_d0y_reg[k] - c_vy_reg[k] * c_d0x_reg[k];
            c_dot0_reg[k]  <= c_d0x_reg[k] * c_vx_reg[k] + c_d0y_reg[k] * c_vy_reg[k];
            c_dot1_reg[k]  <= c_d1x_reg[k] * c_vx_reg[k] + c_d1y_reg[k] * c_vy_reg[k];
            c_en3_reg[k]   <= c_en2_reg[k];
            s_den_reg[k]   <= s_v1x_reg[k] * s_v2y_reg[k] - s_v1y_reg[k] * s_v2x_reg[k];
            s_n1_reg[k]    <= s_dx_reg[k] * s_v2y_reg[k] - s_dy_reg[k] * s_v2x_reg[k];
            s_n2_reg[k]    <= s_dx_reg[k] * s_v1y_reg[k] - s_dy_reg[k] * s_v1x_reg[k];
            s_en3_reg[k]   <= s_en2_reg[k];
            // stage 4
            c_pt4_reg[k]  <= c_en3_reg[k] &&
                             (c_pt0_reg[k] <= c_rr_reg[k] || c_pt1_reg[k] <= c_rr_reg[k]);
            c_lin4_reg[k] <= c_en3_reg[k] && c_vv_reg[k] != 0 &&
                             c_dot0_reg[k] >= 0 && c_dot1_reg[k] <= 0;
            c_ac_reg[k]   <= c_acs[k][34:0];
            c_r2_reg[k]   <= c_rr_reg[k][32:0];
            c_vv4_reg[k]  <= c_vv_reg[k][33:0];
            // stage 5: squares and the r2 * vv product split into narrow partial products
            c_ah2_reg[k]  <= c_ac_reg[k][34:17] * c_ac_reg[k][34:17];
            c_ahal_reg[k] <= c_ac_reg[k][34:17] * c_ac_reg[k][16:0];
            c_al2_reg[k]  <= c_ac_reg[k][16:0] * c_ac_reg[k][16:0];
            c_rvh_reg[k]  <= c_r2_reg[k] * c_vv4_reg[k][33:17];
            c_rvl_reg[k]  <= c_r2_reg[k] * c_vv4_reg[k][16:0];
            c_pt5_reg[k]  <= c_pt4_reg[k];
            c_lin5_reg[k] <= c_lin4_reg[k];
        end
        cc_dx_reg   <= cc_dx_next;
        cc_dy_reg   <= cc_dy_next;
        cc_rs_reg   <= cc_rs_next;
        cc_en2_reg  <= cc_en_next;
        rr_hit2_reg <= rr_hit_next;
        ss2_reg     <= ss_next;
        cc_d_reg    <= cc_dx_reg * cc_dx_reg + cc_dy_reg * cc_dy_reg;
        cc_r_reg    <= cc_rs_reg * cc_rs_reg;
        cc_en3_reg  <= cc_en2_reg;
        rr_hit3_reg <= rr_hit2_reg;
        ss3_reg     <= ss2_reg;
        hit4_reg    <= rr_hit3_reg | (cc_en3_reg && cc_d_reg <= cc_r_reg) | s_any;
        rv4_reg     <= ss3_reg && s_den_reg[0] != 0;
        hit5_reg    <= hit4_reg;
        rv5_reg     <= rv4_reg;
        hit6_reg    <= hit5_reg | c_any;
        rv6_reg     <= rv5_reg;
        res_reg.hit         <= dl_reg[DL-1].hit;
        res_reg.ratio_valid <= dl_reg[DL-1].ratio_valid;
        res_reg.ratio_a     <= dl_reg[DL-1].ratio_valid ? div_a : '0;
        res_reg.ratio_b     <= dl_reg[DL-1].ratio_valid ? div_b : '0;
    end

    spct_ratio_div u_div_a (
        .clk   (clk),
        .num   (s_n1_reg[0]),
        .den   (s_den_reg[0]),
        .ratio (div_a)
    );

    spct_ratio_div u_div_b (
        .clk   (clk),
        .num   (s_n2_reg[0]),
        .den   (s_den_reg[0]),
        .ratio (div_b)
    );

    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(spct_pkg::SAMPLE_LAT) done)
        else $error("request did not produce a result on time");

    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, spct_pkg::SAMPLE_LAT))
        else $error("result without a matching request");

    a_ratio_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.ratio_valid |-> result.ratio_a == '0 && result.ratio_b == '0)
        else $error("ratios set without a valid segment pair");

endmodule

// ===== tb/tb_shape_pair_collision_test.sv =====
`timescale 1ns / 1ps

module tb_shape_pair_collision_test;

    localparam int unsigned STALL_LIMIT = 2000;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
    } seg_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    spct_pkg::spct_req_t req;
    logic                done;
    spct_pkg::spct_res_t result;

    spct_pkg::spct_res_t pending_results[$];
    int                  errors;
    int unsigned         quiet_cycles;

    shape_pair_collision_test dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------- collision arithmetic ----------------

    function automatic logic signed [63:0] cross2(input logic signed [63:0] ax, ay, bx, by);
        return ax * by - ay * bx;
    endfunction

    function automatic bit in_unit(input logic signed [63:0] n, d);
        if (d > 0)
            return n >= 0 && n <= d;
        return n <= 0 && n >= d;
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // n / d in Q.16, truncated toward zero, saturated to 32 bits
    function automatic logic [31:0] fixed_quotient(input logic signed [63:0] n, d);
        logic [63:0] an, ad, q, rem;
        bit          neg;
        an  = magnitude(n);
        ad  = magnitude(d);
        neg = (n < 0) != (d < 0);
        q   = an / ad;
        rem = an % ad;
        if ((q >> (31 - spct_pkg::RATIO_FRAC)) != 0)
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        for (int i = 0; i < spct_pkg::RATIO_FRAC; i++)
        begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= ad)
            begin
                rem = rem - ad;
                q   = q | 64'd1;
            end
        end
        return neg ? 32'(-q) : q[31:0];
    endfunction

    function automatic bit segs_cross(input seg_t s1, s2,
                                      output logic signed [63:0] n1, n2, den);
        logic signed [63:0] dx, dy;
        n1  = 0;
        n2  = 0;
        den = cross2(s1.dx, s1.dy, s2.dx, s2.dy);
        if (den == 0)
            return 1'b0;
        dx = s2.x - s1.x;
        dy = s2.y - s1.y;
        n1 = cross2(dx, dy, s2.dx, s2.dy);
        n2 = cross2(dx, dy, s1.dx, s1.dy);
        return in_unit(n1, den) && in_unit(n2, den);
    endfunction

    function automatic bit point_in_circle(input logic signed [63:0] cx, cy, r, px, py);
        logic signed [63:0] dx, dy;
        dx = px - cx;
        dy = py - cy;
        return dx * dx + dy * dy <= r * r;
    endfunction

    function automatic bit circle_meets_seg(input logic signed [63:0] cx, cy, r, input seg_t s);
        logic signed [63:0] ex, ey, rr, vv;
        logic [63:0]        ac;
        logic [127:0]       lhs, rhs;
        ex = s.x + s.dx;
        ey = s.y + s.dy;
        if (point_in_circle(cx, cy, r, s.x, s.y) || point_in_circle(cx, cy, r, ex, ey))
            return 1'b1;
        if (s.dx == 0 && s.dy == 0)
            return 1'b0;
        ac  = magnitude(cross2(s.dx, s.dy, cx - s.x, cy - s.y));
        rr  = r * r;
        vv  = s.dx * s.dx + s.dy * s.dy;
        lhs = {64'd0, ac} * {64'd0, ac};
        rhs = {64'd0, rr} * {64'd0, vv};
        if (lhs > rhs)
            return 1'b0;
        return (cx - s.x) * s.dx + (cy - s.y) * s.dy >= 0 &&
               (cx - ex) * s.dx + (cy - ey) * s.dy <= 0;
    endfunction

    // doubled centre, full extents; edges up, right, down, left
    function automatic seg_t rect_edge(input logic signed [63:0] x, y, w, h, input int k);
        seg_t e;
        case (k)
            0: e = '{x - w, y + h, 0, -2 * h};
            1: e = '{x - w, y - h, 2 * w, 0};
            2: e = '{x + w, y - h, 0, 2 * h};
            default: e = '{x + w, y + h, -2 * w, 0};
        endcase
        return e;
    endfunction

    function automatic spct_pkg::spct_res_t collision_of(input spct_pkg::spct_req_t r);
        logic signed [63:0] ax, ay, ap, aq, bx, by, bp, bq, n1, n2, den;
        seg_t                sa, sb;
        spct_pkg::spct_res_t res;
        ax  = 2 * 64'(r.a_x);
        ay  = 2 * 64'(r.a_y);
        ap  = 64'(r.a_p);
        aq  = 64'(r.a_q);
        bx  = 2 * 64'(r.b_x);
        by  = 2 * 64'(r.b_y);
        bp  = 64'(r.b_p);
        bq  = 64'(r.b_q);
        sa  = '{ax, ay, 2 * ap, 2 * aq};
        sb  = '{bx, by, 2 * bp, 2 * bq};
        res = '0;
        case (r.req_type)
            spct_pkg::REQ_RECT_RECT:
                res.hit = ax - ap <= bx + bp && ax + ap >= bx - bp &&
                          ay - aq <= by + bq && ay + aq >= by - bq;
            spct_pkg::REQ_CIRC_CIRC:
                res.hit = point_in_circle(ax, ay, 2 * ap + 2 * bp, bx, by);
            spct_pkg::REQ_SEG_SEG:
            begin
                res.hit = segs_cross(sa, sb, n1, n2, den);
                if (den != 0)
                begin
                    res.ratio_valid = 1'b1;
                    res.ratio_a     = fixed_quotient(n1, den);
                    res.ratio_b     = fixed_quotient(n2, den);
                end
            end
            spct_pkg::REQ_RECT_CIRC:
                for (int i = 0; i < 4 && !res.hit; i++)
                    res.hit = circle_meets_seg(bx, by, 2 * bp, rect_edge(ax, ay, ap, aq, i));
            spct_pkg::REQ_RECT_SEG:
                for (int i = 0; i < 4 && !res.hit; i++)
                    res.hit = segs_cross(rect_edge(ax, ay, ap, aq, i), sb, n1, n2, den);
            spct_pkg::REQ_CIRC_SEG:
                res.hit = circle_meets_seg(ax, ay, 2 * ap, sb);
            default: ;
        endcase
        return res;
    endfunction

    // ---------------- driving ----------------

    task automatic send_request(input spct_pkg::spct_req_t r);
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(collision_of(r));
    endtask

    task automatic idle_for(input int unsigned n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic maybe_idle();
        if ($urandom_range(0, 3) == 0)
            idle_for($urandom_range(1, 18));
    endtask

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1:
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sd0;
                    default: return -16'sd1;
                endcase
            2: return 16'($urandom_range(0, 8000)) - 16'sd4000;
            default: return 16'($urandom_range(0, 400)) - 16'sd200;
        endcase
    endfunction

    function automatic spct_pkg::spct_req_t random_request();
        spct_pkg::spct_req_t r;
        r.req_type = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(0, 5));
        r.a_x = pick_coord();
        r.a_y = pick_coord();
        r.a_p = pick_coord();
        r.a_q = pick_coord();
        r.b_x = pick_coord();
        r.b_y = pick_coord();
        r.b_p = pick_coord();
        r.b_q = pick_coord();
        return r;
    endfunction

    function automatic spct_pkg::spct_req_t make_req(input logic [2:0] t,
                                                     input int ax, ay, ap, aq,
                                                     bx, by, bp, bq);
        return '{t, 16'(ax), 16'(ay), 16'(ap), 16'(aq),
                 16'(bx), 16'(by), 16'(bp), 16'(bq)};
    endfunction

    // ---------------- tests ----------------

    task automatic test_directed();
        send_request(make_req(spct_pkg::REQ_RECT_RECT,
                              16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                              16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
        // edges apart along x
        send_request(make_req(spct_pkg::REQ_RECT_RECT, 0, 0, 10, 10, 20, 0, 10, 10));
        // swapped edges
        send_request(make_req(spct_pkg::REQ_RECT_RECT, 0, 0, -10, 10, 25, 0, 10, 10));
        // just touching
        send_request(make_req(spct_pkg::REQ_CIRC_CIRC, 0, 0, 3, 0, 5, 0, 2, 0));
        // negative radius
        send_request(make_req(spct_pkg::REQ_CIRC_CIRC, 0, 0, -3, 0, 6, 0, 2, 0));
        send_request(make_req(spct_pkg::REQ_CIRC_CIRC,
                              16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                              16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000));
        // crossing
        send_request(make_req(spct_pkg::REQ_SEG_SEG, 0, 0, 10, 10, 0, 10, 10, -10));
        // parameter of one
        send_request(make_req(spct_pkg::REQ_SEG_SEG, 0, 0, 10, 0, 10, -5, 0, 10));
        // parallel
        send_request(make_req(spct_pkg::REQ_SEG_SEG, 0, 0, 10, 0, 0, 5, 20, 0));
        // saturation
        send_request(make_req(spct_pkg::REQ_SEG_SEG, 16'sh8000, 16'sh8000, 1, 0,
                              16'sh7FFF, 16'sh7FFF, 0, 1));
        // zero length
        send_request(make_req(spct_pkg::REQ_SEG_SEG, 0, 0, 0, 0, 0, 0, 5, 5));
        // circle inside
        send_request(make_req(spct_pkg::REQ_RECT_CIRC, 0, 0, 100, 100, 0, 0, 5, 0));
        send_request(make_req(spct_pkg::REQ_RECT_CIRC, 0, 0, 100, 100, 55, 0, 6, 0));
        // seg inside
        send_request(make_req(spct_pkg::REQ_RECT_SEG, 0, 0, 100, 100, -10, -10, 5, 5));
        send_request(make_req(spct_pkg::REQ_RECT_SEG, 0, 0, 100, 100, -80, 0, 160, 0));
        // passes through
        send_request(make_req(spct_pkg::REQ_CIRC_SEG, 0, 0, 5, 0, -20, 3, 40, 0));
        // zero length
        send_request(make_req(spct_pkg::REQ_CIRC_SEG, 0, 0, 5, 0, 30, 30, 0, 0));
        // end inside
        send_request(make_req(spct_pkg::REQ_CIRC_SEG, 0, 0, -5, 0, 4, 0, 10, 0));
        send_request(make_req(3'd6, 1, 2, 3, 4, 5, 6, 7, 8));
        send_request(make_req(3'd7, -1, -1, -1, -1, -1, -1, -1, -1));
        idle_for(1);
    endtask

    task automatic test_random_gapped(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            send_request(random_request());
            maybe_idle();
        end
    endtask

    task automatic test_drain_pause();
        send_request(random_request());
        idle_for(1);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_back_to_back(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_request(random_request());
        idle_for(1);
    endtask

    // ---------------- checking ----------------

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: got %p", $time, result);
                errors++;
            end
            else
            begin
                spct_pkg::spct_res_t exp_r;
                exp_r = pending_results.pop_front();
                if (result.hit !== exp_r.hit)
                begin
                    $display("%0t hit: exp %0d got %0d", $time, exp_r.hit, result.hit);
                    errors++;
                end
                if (result.ratio_valid !== exp_r.ratio_valid)
                begin
                    $display("%0t ratio_valid: exp %0d got %0d", $time,
                             exp_r.ratio_valid, result.ratio_valid);
                    errors++;
                end
                if (result.ratio_a !== exp_r.ratio_a)
                begin
                    $display("%0t ratio_a: exp %h got %h", $time, exp_r.ratio_a, result.ratio_a);
                    errors++;
                end
                if (result.ratio_b !== exp_r.ratio_b)
                begin
                    $display("%0t ratio_b: exp %h got %h", $time, exp_r.ratio_b, result.ratio_b);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        errors       = 0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_gapped(400);
        test_drain_pause();
        test_random_gapped(300);
        test_back_to_back(250);

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (spct_pkg::SAMPLE_LAT + 5) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
